@@ rtl/cst_pkg.sv @@
// Shared types, command codes and constants for the countdown seconds timer.
// No dependencies; every other file imports this package.
package cst_pkg;

    localparam int SECONDS_WIDTH_DEF = 16;
    localparam int CMD_W             = 3;
    localparam int VAL_W             = 16;
    localparam int MS_W              = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 1;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd1;

    localparam logic [CFG_DATA_W-1:0] TICK_PERIOD_RST = 16'd1000;
    localparam logic [MS_W-1:0]       MS_MAX          = 16'hFFFF;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [VAL_W-1:0] new_remaining;
    } t_item;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] duration_seconds;
        logic [CFG_DATA_W-1:0] tick_period;
    } t_cfg;

endpackage

@@ rtl/cst_if.sv @@
// Valid/ready channel interfaces for the countdown seconds timer:
// command input, result output and configuration write. Uses cst_pkg.
interface cst_cmd_if
    import cst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] new_remaining;

    modport source (output valid, command, new_remaining, input ready);
    modport sink   (input valid, command, new_remaining, output ready);
endinterface

interface cst_res_if
    import cst_pkg::*;
#(
    parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [SECONDS_WIDTH-1:0] remaining;
    logic                     running;
    logic                     finished;
    logic                     second_pulse;
    logic                     status_led;

    modport source (output valid, remaining, running, finished, second_pulse, status_led,
                    input ready);
    modport sink   (input valid, remaining, running, finished, second_pulse, status_led,
                    output ready);
endinterface

interface cst_cfg_if
    import cst_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/cst_cfg_regs.sv @@
// Configuration registers: countdown duration and prescaler period.
// Depends on cst_pkg and cst_cfg_if.
module cst_cfg_regs
    import cst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cst_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duration_seconds <= '0;
            r_cfg.tick_period      <= TICK_PERIOD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DURATION:    r_cfg.duration_seconds <= i_cfg.data;
                CFG_TICK_PERIOD: r_cfg.tick_period      <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

@@ rtl/cst_in_stage.sv @@
// Input register for command items, full-rate pipeline stage.
// Depends on cst_pkg and cst_cmd_if.
module cst_in_stage
    import cst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cst_cmd_if.sink   i_cmd,
    output logic      o_valid,
    output t_item     o_item,
    input  logic      i_ready
);

    logic  r_valid;
    t_item r_item;

    // take a new transfer when empty or when the held item moves on
    assign i_cmd.ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_item.command       <= i_cmd.command;
            r_item.new_remaining <= i_cmd.new_remaining;
        end
    end

endmodule

@@ rtl/cst_core.sv @@
// Timer state, command decode and result register.
// Depends on cst_pkg and cst_res_if.
module cst_core
    import cst_pkg::*;
#(
    parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_item     i_item,
    output logic      o_ready,
    input  t_cfg      i_cfg,
    cst_res_if.source o_res
);

    logic [SECONDS_WIDTH-1:0] r_secs, n_secs;
    logic [MS_W-1:0]          r_ms, n_ms;
    logic                     r_run, n_run;
    logic                     r_fin, n_fin;
    logic                     r_led, n_led;
    logic                     n_pulse;

    logic                     r_out_valid;
    logic [SECONDS_WIDTH-1:0] r_res_secs;
    logic                     r_res_run;
    logic                     r_res_fin;
    logic                     r_res_pulse;
    logic                     r_res_led;

    logic                     advance;
    logic [SECONDS_WIDTH-1:0] dur;
    logic [SECONDS_WIDTH-1:0] set_val;
    logic [SECONDS_WIDTH-1:0] secs_dec;
    logic [SECONDS_WIDTH-1:0] secs_ld;
    logic [MS_W-1:0]          ms_inc;

    assign o_ready = !r_out_valid || o_res.ready;
    assign advance = i_valid && o_ready;

    assign dur      = SECONDS_WIDTH'(i_cfg.duration_seconds);
    assign set_val  = SECONDS_WIDTH'(i_item.new_remaining);
    assign ms_inc   = r_ms + 1'b1;
    assign secs_dec = (r_secs != '0) ? r_secs - 1'b1 : r_secs;
    assign secs_ld  = (r_secs == '0) ? dur : r_secs;

    always_comb begin
        n_secs  = r_secs;
        n_ms    = r_ms;
        n_run   = r_run;
        n_fin   = r_fin;
        n_led   = r_led;
        n_pulse = 1'b0;
        unique case (i_item.command)
            CMD_TICK: begin
                if (r_run) begin
                    // a zero period never matches, so every tick counts a second
                    if (ms_inc < i_cfg.tick_period && r_ms != MS_MAX) begin
                        n_ms = ms_inc;
                    end else begin
                        n_ms    = '0;
                        n_led   = !r_led;
                        n_secs  = secs_dec;
                        n_pulse = (r_secs != '0);
                        if (secs_dec == '0) begin
                            n_run = 1'b0;
                            n_fin = 1'b1;
                            n_led = 1'b1;
                        end
                    end
                end
            end
            CMD_START: begin
                n_secs = secs_ld;
                if (secs_ld != '0) begin
                    n_ms  = '0;
                    n_run = 1'b1;
                    n_fin = 1'b0;
                    n_led = 1'b0;
                end
            end
            CMD_STOP: begin
                n_run = 1'b0;
                n_led = 1'b0;
            end
            CMD_RESET: begin
                n_run  = 1'b0;
                n_fin  = 1'b0;
                n_secs = dur;
                n_led  = 1'b0;
            end
            CMD_SET: begin
                n_secs = set_val;
                n_fin  = 1'b0;
                n_ms   = '0;
                if (set_val == '0) begin
                    n_run = 1'b0;
                    n_fin = 1'b1;
                    n_led = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secs      <= '0;
            r_ms        <= '0;
            r_run       <= 1'b0;
            r_fin       <= 1'b0;
            r_led       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_secs <= n_secs;
                r_ms   <= n_ms;
                r_run  <= n_run;
                r_fin  <= n_fin;
                r_led  <= n_led;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res_secs  <= n_secs;
            r_res_run   <= n_run;
            r_res_fin   <= n_fin;
            r_res_pulse <= n_pulse;
            r_res_led   <= n_led;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.remaining    = r_res_secs;
    assign o_res.running      = r_res_run;
    assign o_res.finished     = r_res_fin;
    assign o_res.second_pulse = r_res_pulse;
    assign o_res.status_led   = r_res_led;

endmodule

@@ rtl/countdown_seconds_timer.sv @@
// Countdown seconds timer: command input register, state update, result register.
// A command passes the input register, then the state update and the result
// register, before its result is valid. Throughput: one command per cycle while
// the result output is not stalled; the state update feeds back on its own registers.
// Synchronous active-low reset clears timer state, pipeline valids and sets
// duration to 0 and tick period to 1000. Depends on cst_pkg and cst_if.
module countdown_seconds_timer
    import cst_pkg::*;
#(
    parameter int SECONDS_WIDTH = SECONDS_WIDTH_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cst_cmd_if.sink   i_cmd,
    cst_cfg_if.sink   i_cfg,
    cst_res_if.source o_res
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  item_ready;

    cst_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    cst_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (item_valid),
        .o_item  (item),
        .i_ready (item_ready)
    );

    cst_core #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .o_ready (item_ready),
        .i_cfg   (cfg),
        .o_res   (o_res)
    );

endmodule

@@ bench/tb_countdown_seconds_timer.sv @@
// Testbench for countdown_seconds_timer: directed and random command streams,
// checked per result against an in-bench timer model. Uses cst_pkg and cst_if.
module tb_countdown_seconds_timer;
    import cst_pkg::*;

    localparam int SW         = SECONDS_WIDTH_DEF;
    localparam int CYCLE_MAX  = 200000;
    localparam int HOLD_LEN   = 400;
    localparam int PHASES     = 8;
    localparam int PHASE_CMDS = 55;

    typedef struct packed {
        logic [SW-1:0] remaining;
        logic          running;
        logic          finished;
        logic          second_pulse;
        logic          status_led;
    } t_status;

    logic i_clk;
    logic i_rst_n;

    cst_cmd_if                       cmd_if ();
    cst_cfg_if                       cfg_if ();
    cst_res_if #(.SECONDS_WIDTH(SW)) res_if ();

    countdown_seconds_timer #(.SECONDS_WIDTH(SW)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // timer model state and shadow registers
    logic [SW-1:0]         secs_left;
    logic [MS_W-1:0]       ms_count;
    logic                  is_running;
    logic                  is_finished;
    logic                  led_on;
    logic [CFG_DATA_W-1:0] duration_reg;
    logic [CFG_DATA_W-1:0] period_reg;

    t_item   cmd_backlog[$];
    t_status status_due[$];

    int   errors     = 0;
    int   send_pct   = 30;
    int   recv_pct   = 30;
    logic hold_start = 1'b0;
    logic hold_ready = 1'b0;
    logic cmd_fire   = 1'b0;
    logic cfg_fire   = 1'b0;
    int   cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_status timer_next_status(t_item it);
        t_status         st;
        logic [MS_W-1:0] nxt;
        logic            pulse;
        pulse = 1'b0;
        case (it.command)
            CMD_TICK: begin
                if (is_running) begin
                    nxt = ms_count + 1'b1;
                    if (nxt < period_reg && ms_count != MS_MAX) begin
                        ms_count = nxt;
                    end else begin
                        ms_count = '0;
                        led_on   = ~led_on;
                        if (secs_left != 0) begin
                            secs_left = secs_left - 1'b1;
                            pulse     = 1'b1;
                        end
                        if (secs_left == 0) begin
                            is_running  = 1'b0;
                            is_finished = 1'b1;
                            led_on      = 1'b1;
                        end
                    end
                end
            end
            CMD_START: begin
                if (secs_left == 0)
                    secs_left = duration_reg[SW-1:0];
                if (secs_left != 0) begin
                    ms_count    = '0;
                    is_running  = 1'b1;
                    is_finished = 1'b0;
                    led_on      = 1'b0;
                end
            end
            CMD_STOP: begin
                is_running = 1'b0;
                led_on     = 1'b0;
            end
            CMD_RESET: begin
                is_running  = 1'b0;
                is_finished = 1'b0;
                secs_left   = duration_reg[SW-1:0];
                led_on      = 1'b0;
            end
            CMD_SET: begin
                secs_left   = it.new_remaining[SW-1:0];
                is_finished = 1'b0;
                ms_count    = '0;
                if (it.new_remaining[SW-1:0] == 0) begin
                    is_running  = 1'b0;
                    is_finished = 1'b1;
                    led_on      = 1'b1;
                end
            end
            default: ;
        endcase
        st.remaining    = secs_left;
        st.running      = is_running;
        st.finished     = is_finished;
        st.second_pulse = pulse;
        st.status_led   = led_on;
        return st;
    endfunction

    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(15, 60);
        return $urandom_range(1, 3);
    endfunction

    task automatic report(string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
        t_item it;
        it.command       = cmd;
        it.new_remaining = val;
        cmd_backlog.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        cfg_if.valid <= 1'b0;
    endtask

    // sender stops until every queued command has produced its result
    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || status_due.size() != 0);
    endtask

    // command driver
    always @(negedge i_clk) begin : cmd_driver
        t_item it;
        int    gap;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            gap = 0;
        end else if (!cmd_if.valid || cmd_fire) begin
            if (gap > 0 || cmd_backlog.size() == 0) begin
                if (gap > 0)
                    gap--;
                cmd_if.valid <= 1'b0;
            end else begin
                it = cmd_backlog.pop_front();
                cmd_if.valid         <= 1'b1;
                cmd_if.command       <= it.command;
                cmd_if.new_remaining <= it.new_remaining;
                gap = pick_gap(send_pct);
            end
        end
    end

    // result ready driver
    always @(negedge i_clk) begin : res_driver
        int gap;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            gap = 0;
        end else if (hold_ready) begin
            res_if.ready <= 1'b0;
        end else if (gap > 0) begin
            gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            gap = pick_gap(recv_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin : hold_off
        wait (hold_start);
        @(negedge i_clk);
        hold_ready <= 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        hold_ready <= 1'b0;
    end

    // transfer tracking, prediction and checking
    always @(posedge i_clk) begin : monitor
        t_item   it;
        t_status got;
        t_status want;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            cmd_fire     <= 1'b0;
            cfg_fire     <= 1'b0;
            duration_reg = '0;
            period_reg   = TICK_PERIOD_RST;
            secs_left    = '0;
            ms_count     = '0;
            is_running   = 1'b0;
            is_finished  = 1'b0;
            led_on       = 1'b0;
        end else begin
            cmd_fire <= cmd_if.valid && cmd_if.ready;
            cfg_fire <= cfg_if.valid && cfg_if.ready;
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == CFG_DURATION)
                    duration_reg = cfg_if.data;
                else if (cfg_if.index == CFG_TICK_PERIOD)
                    period_reg = cfg_if.data;
            end
            if (cmd_if.valid && cmd_if.ready) begin
                it.command       = cmd_if.command;
                it.new_remaining = cmd_if.new_remaining;
                status_due.push_back(timer_next_status(it));
            end
            if (res_if.valid && res_if.ready) begin
                got.remaining    = res_if.remaining;
                got.running      = res_if.running;
                got.finished     = res_if.finished;
                got.second_pulse = res_if.second_pulse;
                got.status_led   = res_if.status_led;
                if (status_due.size() == 0) begin
                    report($sformatf("result with nothing pending, remaining %0d",
                                     got.remaining));
                end else begin
                    want = status_due.pop_front();
                    if (got.remaining !== want.remaining)
                        report($sformatf("remaining %0d, want %0d",
                                         got.remaining, want.remaining));
                    if (got.running !== want.running)
                        report($sformatf("running %b, want %b", got.running, want.running));
                    if (got.finished !== want.finished)
                        report($sformatf("finished %b, want %b",
                                         got.finished, want.finished));
                    if (got.second_pulse !== want.second_pulse)
                        report($sformatf("second_pulse %b, want %b",
                                         got.second_pulse, want.second_pulse));
                    if (got.status_led !== want.status_led)
                        report($sformatf("status_led %b, want %b",
                                         got.status_led, want.status_led));
                end
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_MAX);
        $display("FAIL countdown_seconds_timer");
        $finish;
    end

    initial begin : stimulus
        int                    n;
        int                    r;
        logic [CFG_DATA_W-1:0] period;
        logic [CFG_DATA_W-1:0] duration;
        logic [VAL_W-1:0]      val;

        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = CMD_TICK;
        cmd_if.new_remaining = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_DURATION;
        cfg_if.data          = '0;
        res_if.ready         = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: duration zero, period 1000
        queue_cmd(CMD_TICK, 16'h0000);      // tick while stopped
        queue_cmd(CMD_START, 16'hFFFF);     // refused, nothing to count
        queue_cmd(3'd5, 16'h5A5A);          // unused codes
        queue_cmd(3'd6, 16'hFFFF);
        queue_cmd(3'd7, 16'h0000);
        queue_cmd(CMD_SET, 16'h0000);       // set to zero finishes
        queue_cmd(CMD_SET, 16'hFFFF);
        queue_cmd(CMD_START, 16'h0000);
        queue_cmd(CMD_TICK, 16'hA5A5);
        queue_cmd(CMD_STOP, 16'h0000);
        queue_cmd(CMD_SET, 16'h0003);
        wait_drained();

        write_reg(CFG_DURATION, 16'd2);
        write_reg(CFG_TICK_PERIOD, 16'd1);
        queue_cmd(CMD_RESET, 16'h0000);
        queue_cmd(CMD_START, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);      // reaches zero
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_START, 16'h0000);     // reload from duration
        queue_cmd(CMD_START, 16'h0000);     // restart while running
        queue_cmd(CMD_SET, 16'h8001);       // nonzero set keeps running
        wait_drained();

        write_reg(CFG_TICK_PERIOD, 16'd0);  // zero period acts as one
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);
        wait_drained();

        write_reg(CFG_DURATION, 16'hFFFF);
        write_reg(CFG_TICK_PERIOD, 16'hFFFF);
        queue_cmd(CMD_RESET, 16'h0000);
        queue_cmd(CMD_START, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_TICK, 16'h0000);
        wait_drained();

        // period drops below the prescaler count
        write_reg(CFG_TICK_PERIOD, 16'd2);
        queue_cmd(CMD_TICK, 16'h0000);
        queue_cmd(CMD_STOP, 16'h0000);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                2: begin
                    period   = 16'hFFFF;
                    duration = 16'hFFFF;
                end
                4: begin
                    period   = 16'd1;
                    duration = 16'd0;
                end
                6: begin
                    period   = 16'd1;
                    duration = 16'd1;
                end
                default: begin
                    period   = CFG_DATA_W'($urandom_range(1, 6));
                    duration = CFG_DATA_W'($urandom_range(1, 9));
                end
            endcase
            send_pct = (p == 3 || p == 6) ? 0 : 30;
            recv_pct = (p == 6) ? 0 : 30;
            write_reg(CFG_DURATION, duration);
            write_reg(CFG_TICK_PERIOD, period);

            queue_cmd(CMD_RESET, VAL_W'($urandom));
            queue_cmd(CMD_START, VAL_W'($urandom));
            for (n = 2; n < PHASE_CMDS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    queue_cmd(CMD_TICK, VAL_W'($urandom));
                end else if (r < 70) begin
                    queue_cmd(CMD_START, VAL_W'($urandom));
                end else if (r < 76) begin
                    queue_cmd(CMD_STOP, VAL_W'($urandom));
                end else if (r < 82) begin
                    queue_cmd(CMD_RESET, VAL_W'($urandom));
                end else if (r < 90) begin
                    val = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom)
                                                      : VAL_W'($urandom_range(0, 5));
                    queue_cmd(CMD_SET, val);
                end else if (r < 95) begin
                    queue_cmd(CMD_W'($urandom_range(5, 7)), VAL_W'($urandom));
                end else begin
                    queue_cmd(CMD_TICK, VAL_W'($urandom));
                end
            end
            if (p == 3)
                hold_start = 1'b1;
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0)
            $display("PASS countdown_seconds_timer");
        else
            $display("FAIL countdown_seconds_timer");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cst_pkg.sv
rtl/cst_if.sv
rtl/cst_cfg_regs.sv
rtl/cst_in_stage.sv
rtl/cst_core.sv
rtl/countdown_seconds_timer.sv
bench/tb_countdown_seconds_timer.sv
